[sv/qvr_pkg.sv]
// Package for the quaternion vector rotation unit.
// Holds the epsilon register width and reset value; no dependencies.
`default_nettype none

package qvr_pkg;

   // Width and reset value of the length epsilon register.
   localparam int EPS_WIDTH = 12;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 12'd1;

endpackage

`default_nettype wire

[sv/qvr_sqrt_cell.sv]
// One cell of the square root chain: settles one root bit per cell.
// Depends on nothing; instantiated in a row by the top level.
`default_nettype none

module qvr_sqrt_cell #(
   parameter int SUM_W  = 33,
   parameter int ROOT_W = 17,
   parameter int PASS_W = 1,
   parameter int STEP   = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [SUM_W-1:0]  in_rem,
   input  wire logic [ROOT_W-1:0] in_root,
   input  wire logic [PASS_W-1:0] in_pass,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [SUM_W-1:0]       out_rem,
   output logic [ROOT_W-1:0]      out_root,
   output logic [PASS_W-1:0]      out_pass
);

   localparam int TRIAL_W = SUM_W + 2;

   logic                valid_ff;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [PASS_W-1:0]   pass_ff;
   logic [TRIAL_W-1:0]  trial;
   logic                take;

   // The cell moves whenever it is empty or its neighbor takes its item.
   assign in_ready = !valid_ff || out_ready;

   // Try to set this root bit: (y + 2^i)^2 - y^2 = y*2^(i+1) + 2^(2i).
   always_comb begin
      trial   = (TRIAL_W'(in_root) << (STEP + 1)) + (TRIAL_W'(1) << (2 * STEP));
      take    = TRIAL_W'(in_rem) >= trial;
      rem_in  = take ? (in_rem - trial[SUM_W-1:0]) : in_rem;
      root_in = take ? (in_root | (ROOT_W'(1) << STEP)) : in_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         pass_ff <= in_pass;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_pass  = pass_ff;

endmodule

`default_nettype wire

[sv/qvr_div_cell.sv]
// One cell of the restoring divider chain: one quotient bit for four lanes.
// Depends on nothing; instantiated in a row by the top level.
`default_nettype none

module qvr_div_cell #(
   parameter int LEN_W  = 17,
   parameter int REM_W  = 29,
   parameter int QUO_W  = 13,
   parameter int PASS_W = 1,
   parameter int STEP   = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [LEN_W-1:0]     in_len,
   input  wire logic [4*REM_W-1:0]   in_rem,
   input  wire logic [4*QUO_W-1:0]   in_quo,
   input  wire logic [PASS_W-1:0]    in_pass,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [LEN_W-1:0]          out_len,
   output logic [4*REM_W-1:0]        out_rem,
   output logic [4*QUO_W-1:0]        out_quo,
   output logic [PASS_W-1:0]         out_pass
);

   logic                valid_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [4*REM_W-1:0]  rem_ff, rem_in;
   logic [4*QUO_W-1:0]  quo_ff, quo_in;
   logic [PASS_W-1:0]   pass_ff;
   logic [REM_W-1:0]    divisor;

   assign in_ready = !valid_ff || out_ready;

   // Subtract the shifted divisor from each lane where it fits.
   always_comb begin
      divisor = REM_W'(in_len) << STEP;
      rem_in  = in_rem;
      quo_in  = in_quo;
      for (int l = 0; l < 4; l++) begin
         if (in_rem[l*REM_W +: REM_W] >= divisor) begin
            rem_in[l*REM_W +: REM_W] = in_rem[l*REM_W +: REM_W] - divisor;
            quo_in[l*QUO_W +: QUO_W] = in_quo[l*QUO_W +: QUO_W] | (QUO_W'(1) << STEP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         len_ff  <= in_len;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         pass_ff <= in_pass;
      end
   end

   assign out_valid = valid_ff;
   assign out_len   = len_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_pass  = pass_ff;

endmodule

`default_nettype wire

[sv/qvr_rotate.sv]
// Rotation datapath: signs the normalized components, forms t and r,
// rounds and saturates. Five register stages; depends on nothing.
`default_nettype none

module qvr_rotate #(
   parameter int VW    = 24,
   parameter int F     = 12,
   parameter int QUO_W = 13
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [4*QUO_W-1:0]  in_quo,
   input  wire logic [3:0]          in_sign,
   input  wire logic [3*VW-1:0]     in_vec,
   input  wire logic                in_degenerate,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [VW-1:0]            out_rot_x,
   output logic [VW-1:0]            out_rot_y,
   output logic [VW-1:0]            out_rot_z,
   output logic                     out_degenerate
);

   localparam int NW   = F + 2;
   localparam int PMW  = NW + VW;
   localparam int XW   = PMW + 3;
   localparam int TW   = XW - F;
   localparam int MMW  = NW + TW;
   localparam int RRW  = ((VW + F > MMW) ? VW + F : MMW) + 2;
   localparam int SRW  = RRW + 1;

   localparam logic signed [XW-1:0]  T_HALF = $signed(XW'(1) << (F - 1));
   localparam logic signed [SRW-1:0] R_HALF = $signed(SRW'(1) << (F - 1));
   localparam logic signed [SRW-1:0] V_MAX  =
      $signed({{(SRW-VW+1){1'b0}}, {(VW-1){1'b1}}});
   localparam logic signed [SRW-1:0] V_MIN  =
      $signed({{(SRW-VW+1){1'b1}}, {(VW-1){1'b0}}});

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // Stage 1: signed normalized components.
   logic signed [NW-1:0]  n1_ff [4];
   logic signed [NW-1:0]  n1_in [4];
   logic signed [VW-1:0]  vec1_ff [3];
   logic                  deg1_ff;
   // Stage 2: products of n and v.
   logic signed [PMW-1:0] p2_ff [6];
   logic signed [PMW-1:0] p2_in [6];
   logic signed [NW-1:0]  n2_ff [4];
   logic signed [VW-1:0]  vec2_ff [3];
   logic                  deg2_ff;
   // Stage 3: t.
   logic signed [TW-1:0]  t3_ff [3];
   logic signed [TW-1:0]  t3_in [3];
   logic signed [NW-1:0]  n3_ff [4];
   logic signed [VW-1:0]  vec3_ff [3];
   logic                  deg3_ff;
   // Stage 4: products of n and t.
   logic signed [MMW-1:0] m4_ff [9];
   logic signed [MMW-1:0] m4_in [9];
   logic signed [VW-1:0]  vec4_ff [3];
   logic                  deg4_ff;
   // Stage 5: output register.
   logic [VW-1:0]         rot5_ff [3];
   logic [VW-1:0]         rot5_in [3];
   logic                  deg5_ff;

   logic signed [XW-1:0]  tx [3];
   logic signed [SRW-1:0] rs [3];
   logic signed [SRW-1:0] rq [3];

   // Each stage moves when empty or when the next one moves.
   assign rdy5     = !v5_ff || out_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // Apply the component signs to the unsigned quotients.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         n1_in[i] = $signed(NW'(in_quo[i*QUO_W +: QUO_W]));
         if (in_sign[i]) begin
            n1_in[i] = -n1_in[i];
         end
      end
   end

   // Cross product terms of n.xyz and v.
   always_comb begin
      p2_in[0] = PMW'(n1_ff[1]) * PMW'(vec1_ff[2]);
      p2_in[1] = PMW'(n1_ff[2]) * PMW'(vec1_ff[1]);
      p2_in[2] = PMW'(n1_ff[2]) * PMW'(vec1_ff[0]);
      p2_in[3] = PMW'(n1_ff[0]) * PMW'(vec1_ff[2]);
      p2_in[4] = PMW'(n1_ff[0]) * PMW'(vec1_ff[1]);
      p2_in[5] = PMW'(n1_ff[1]) * PMW'(vec1_ff[0]);
   end

   // t = 2*cross, rounded half up to Q.F.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tx[i]    = ((XW'(p2_ff[2*i]) - XW'(p2_ff[2*i+1])) <<< 1) + T_HALF;
         t3_in[i] = TW'(tx[i] >>> F);
      end
   end

   // w*t and cross(n.xyz, t) terms.
   always_comb begin
      m4_in[0] = MMW'(n3_ff[3]) * MMW'(t3_ff[0]);
      m4_in[1] = MMW'(n3_ff[3]) * MMW'(t3_ff[1]);
      m4_in[2] = MMW'(n3_ff[3]) * MMW'(t3_ff[2]);
      m4_in[3] = MMW'(n3_ff[1]) * MMW'(t3_ff[2]);
      m4_in[4] = MMW'(n3_ff[2]) * MMW'(t3_ff[1]);
      m4_in[5] = MMW'(n3_ff[2]) * MMW'(t3_ff[0]);
      m4_in[6] = MMW'(n3_ff[0]) * MMW'(t3_ff[2]);
      m4_in[7] = MMW'(n3_ff[0]) * MMW'(t3_ff[1]);
      m4_in[8] = MMW'(n3_ff[1]) * MMW'(t3_ff[0]);
   end

   // Sum at Q.2F, round half up, saturate; a degenerate item passes v.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rs[i] = (SRW'(vec4_ff[i]) <<< F) + SRW'(m4_ff[i])
               + SRW'(m4_ff[3+2*i]) - SRW'(m4_ff[4+2*i]) + R_HALF;
         rq[i] = rs[i] >>> F;
         if (deg4_ff) begin
            rot5_in[i] = vec4_ff[i];
         end else if (rq[i] > V_MAX) begin
            rot5_in[i] = V_MAX[VW-1:0];
         end else if (rq[i] < V_MIN) begin
            rot5_in[i] = V_MIN[VW-1:0];
         end else begin
            rot5_in[i] = rq[i][VW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         n1_ff   <= n1_in;
         for (int i = 0; i < 3; i++) begin
            vec1_ff[i] <= $signed(in_vec[i*VW +: VW]);
         end
         deg1_ff <= in_degenerate;
      end
      if (rdy2) begin
         p2_ff   <= p2_in;
         n2_ff   <= n1_ff;
         vec2_ff <= vec1_ff;
         deg2_ff <= deg1_ff;
      end
      if (rdy3) begin
         t3_ff   <= t3_in;
         n3_ff   <= n2_ff;
         vec3_ff <= vec2_ff;
         deg3_ff <= deg2_ff;
      end
      if (rdy4) begin
         m4_ff   <= m4_in;
         vec4_ff <= vec3_ff;
         deg4_ff <= deg3_ff;
      end
      if (rdy5) begin
         rot5_ff <= rot5_in;
         deg5_ff <= deg4_ff;
      end
   end

   assign out_valid      = v5_ff;
   assign out_rot_x      = rot5_ff[0];
   assign out_rot_y      = rot5_ff[1];
   assign out_rot_z      = rot5_ff[2];
   assign out_degenerate = deg5_ff;

endmodule

`default_nettype wire

[sv/quaternion_vector_rotation_unit.sv]
// Quaternion vector rotation unit, top level.
// Uses qvr_pkg, qvr_sqrt_cell, qvr_div_cell and qvr_rotate.
//
// The req channel takes one quaternion (Q4.12) and one vector (Q12.12) per
// item; the rsp channel returns the rotated, saturated vector and a flag
// that marks a quaternion whose length fell to the epsilon register, in
// which case the vector passes unchanged. The csr channel writes the
// epsilon register and is always ready; write it only while the unit is
// idle.
// The datapath is a chain of cells with a valid bit each: one squaring
// stage, QUAT_WIDTH+1 square root cells (one root bit each), FRAC_BITS+1
// divider cells (one quotient bit each, four lanes) and five rotation
// stages. One item can be accepted every cycle while req_ready is high.
// A stage moves whenever it is empty or the next one moves, so when the
// receiver stalls the items close up behind the output register and
// req_ready falls only once every stage is full. Reset empties the chain
// and sets epsilon to 1.
`default_nettype none

module quaternion_vector_rotation_unit #(
   parameter int QUAT_WIDTH = 16,
   parameter int VEC_WIDTH  = 24,
   parameter int FRAC_BITS  = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [QUAT_WIDTH-1:0]      req_quat_x,
   input  wire logic signed [QUAT_WIDTH-1:0]      req_quat_y,
   input  wire logic signed [QUAT_WIDTH-1:0]      req_quat_z,
   input  wire logic signed [QUAT_WIDTH-1:0]      req_quat_w,
   input  wire logic signed [VEC_WIDTH-1:0]       req_vec_x,
   input  wire logic signed [VEC_WIDTH-1:0]       req_vec_y,
   input  wire logic signed [VEC_WIDTH-1:0]       req_vec_z,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [VEC_WIDTH-1:0]            rsp_rot_x,
   output logic signed [VEC_WIDTH-1:0]            rsp_rot_y,
   output logic signed [VEC_WIDTH-1:0]            rsp_rot_z,
   output logic                                   rsp_degenerate,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [qvr_pkg::EPS_WIDTH-1:0]     csr_length_epsilon
);

   localparam int QW     = QUAT_WIDTH;
   localparam int VW     = VEC_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int SW     = 2 * QW + 1;
   localparam int LW     = QW + 1;
   localparam int RW     = QW + F + 1;
   localparam int QB     = F + 1;
   localparam int SPW    = 4 * QW + 4 + 3 * VW;
   localparam int DPW    = 3 * VW + 5;
   localparam int CW     = (LW > qvr_pkg::EPS_WIDTH) ? LW : qvr_pkg::EPS_WIDTH;

   logic [qvr_pkg::EPS_WIDTH-1:0] eps_ff;

   // Front stage: magnitudes and squares.
   logic                 fv_ff, front_ready;
   logic [2*QW-1:0]      sq_ff [4];
   logic [2*QW-1:0]      sq_in [4];
   logic [QW-1:0]        mag_in [4];
   logic [3:0]           sign_in;
   logic [SPW-1:0]       fpass_ff, fpass_in;
   logic signed [QW-1:0] quat [4];

   // Square root chain buses.
   logic            s_valid [LW+1];
   logic            s_ready [LW+1];
   logic [SW-1:0]   s_rem   [LW+1];
   logic [LW-1:0]   s_root  [LW+1];
   logic [SPW-1:0]  s_pass  [LW+1];

   // Divider chain buses.
   logic            d_valid [QB+1];
   logic            d_ready [QB+1];
   logic [LW-1:0]   d_len   [QB+1];
   logic [4*RW-1:0] d_rem   [QB+1];
   logic [4*QB-1:0] d_quo   [QB+1];
   logic [DPW-1:0]  d_pass  [QB+1];

   logic [LW-1:0]   len;
   logic            degenerate;

   // Epsilon register; a write is always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= qvr_pkg::EPS_RESET;
      end else if (csr_valid) begin
         eps_ff <= csr_length_epsilon;
      end
   end

   // Magnitudes, signs and squares of the quaternion components.
   always_comb begin
      quat[0] = req_quat_x;
      quat[1] = req_quat_y;
      quat[2] = req_quat_z;
      quat[3] = req_quat_w;
      for (int i = 0; i < 4; i++) begin
         sign_in[i] = quat[i][QW-1];
         mag_in[i]  = sign_in[i] ? QW'(-quat[i]) : QW'(quat[i]);
         sq_in[i]   = (2*QW)'(mag_in[i]) * (2*QW)'(mag_in[i]);
      end
      fpass_in = {req_vec_z, req_vec_y, req_vec_x, sign_in,
                  mag_in[3], mag_in[2], mag_in[1], mag_in[0]};
   end

   assign front_ready = !fv_ff || s_ready[0];
   assign req_ready   = front_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (front_ready) begin
         fv_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_ready) begin
         sq_ff    <= sq_in;
         fpass_ff <= fpass_in;
      end
   end

   // Sum of squares enters the root chain.
   assign s_valid[0] = fv_ff;
   assign s_rem[0]   = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]) + SW'(sq_ff[3]);
   assign s_root[0]  = '0;
   assign s_pass[0]  = fpass_ff;

   for (genvar j = 0; j < LW; j++) begin : g_sqrt
      qvr_sqrt_cell #(
         .SUM_W  (SW),
         .ROOT_W (LW),
         .PASS_W (SPW),
         .STEP   (LW - 1 - j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (s_valid[j]),
         .in_ready  (s_ready[j]),
         .in_rem    (s_rem[j]),
         .in_root   (s_root[j]),
         .in_pass   (s_pass[j]),
         .out_valid (s_valid[j+1]),
         .out_ready (s_ready[j+1]),
         .out_rem   (s_rem[j+1]),
         .out_root  (s_root[j+1]),
         .out_pass  (s_pass[j+1])
      );
   end

   // Length check and rounded dividends for the divider chain.
   assign len        = s_root[LW];
   assign degenerate = (CW'(len) <= CW'(eps_ff)) || (len == '0);
   assign s_ready[LW] = d_ready[0];
   assign d_valid[0]  = s_valid[LW];
   assign d_len[0]    = len;
   assign d_quo[0]    = '0;
   assign d_pass[0]   = {degenerate, s_pass[LW][SPW-1 -: 3*VW+4]};

   for (genvar l = 0; l < 4; l++) begin : g_dividend
      assign d_rem[0][l*RW +: RW] = (RW'(s_pass[LW][l*QW +: QW]) << F) + RW'(len >> 1);
   end

   for (genvar j = 0; j < QB; j++) begin : g_div
      qvr_div_cell #(
         .LEN_W  (LW),
         .REM_W  (RW),
         .QUO_W  (QB),
         .PASS_W (DPW),
         .STEP   (QB - 1 - j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (d_valid[j]),
         .in_ready  (d_ready[j]),
         .in_len    (d_len[j]),
         .in_rem    (d_rem[j]),
         .in_quo    (d_quo[j]),
         .in_pass   (d_pass[j]),
         .out_valid (d_valid[j+1]),
         .out_ready (d_ready[j+1]),
         .out_len   (d_len[j+1]),
         .out_rem   (d_rem[j+1]),
         .out_quo   (d_quo[j+1]),
         .out_pass  (d_pass[j+1])
      );
   end

   // Rotation datapath and output register.
   qvr_rotate #(
      .VW    (VW),
      .F     (F),
      .QUO_W (QB)
   ) u_rotate (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (d_valid[QB]),
      .in_ready       (d_ready[QB]),
      .in_quo         (d_quo[QB]),
      .in_sign        (d_pass[QB][3:0]),
      .in_vec         (d_pass[QB][3*VW+3:4]),
      .in_degenerate  (d_pass[QB][DPW-1]),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_rot_x      (rsp_rot_x),
      .out_rot_y      (rsp_rot_y),
      .out_rot_z      (rsp_rot_z),
      .out_degenerate (rsp_degenerate)
   );

   // The chain holds no item right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With the output register empty, every stage can move.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled while the output register is empty");

   // An item accepted at the input is not lost at the front.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> fv_ff)
      else $error("accepted item missing from the front stage");

endmodule

`default_nettype wire
